[hw/rtl/t1bf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// T=1 block framer package
// Word layout, result codes and protocol constants shared by the framer.
// ----------------------------------------------------------------------------
package t1bf_pkg;

  localparam int MAX_RESULTS = 5;

  // input word kinds
  localparam logic IN_CMD  = 1'b0;
  localparam logic IN_CARD = 1'b1;

  // result word kinds
  localparam logic [1:0] KIND_CARD   = 2'd0;
  localparam logic [1:0] KIND_HOST   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // completion status codes
  localparam logic [1:0] STATUS_SW    = 2'd0;
  localparam logic [1:0] STATUS_CHAIN = 2'd1;
  localparam logic [1:0] STATUS_ERR   = 2'd2;

  localparam logic [7:0] R_BLOCK_FLAG = 8'h80;
  localparam int         CHAIN_BIT    = 5;
  localparam logic [9:0] MIN_ANSWER   = 10'd6;
  localparam logic [8:0] DATA_START   = 9'd3;
  localparam logic [8:0] POS_PCB      = 9'd1;
  localparam logic [8:0] POS_LEN      = 9'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] status_word;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                count;
    logic [7:0]                response_length;
  } step_t;

endpackage
`default_nettype wire

[hw/rtl/t1bf_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// T=1 framing core
// Holds send and receive framing state and builds the result words of one
// input word in a single pass.
// ----------------------------------------------------------------------------
module t1bf_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           kind,
  input  wire logic [7:0]     data_byte,
  input  wire logic [7:0]     apdu_length,
  input  wire logic           last_byte,
  output t1bf_pkg::step_t     step
);

  logic       sequence_bit, sequence_bit_next;
  logic [7:0] send_count, send_count_next;
  logic [7:0] send_lrc, send_lrc_next;
  logic [8:0] receive_count, receive_count_next;
  logic [7:0] received_pcb, received_pcb_next;
  logic [7:0] received_len, received_len_next;
  logic [7:0] status_high, status_high_next;
  logic [7:0] status_low, status_low_next;
  logic [7:0] gathered_length, gathered_length_next;

  logic [7:0] pcb_i, pcb_r, lrc, limit;
  logic [8:0] d;
  logic       chained, forward;

  always_comb begin
    sequence_bit_next    = sequence_bit;
    send_count_next      = send_count;
    send_lrc_next        = send_lrc;
    receive_count_next   = receive_count;
    received_pcb_next    = received_pcb;
    received_len_next    = received_len;
    status_high_next     = status_high;
    status_low_next      = status_low;
    gathered_length_next = gathered_length;
    step                 = '0;

    pcb_i   = {1'b0, sequence_bit, 6'd0};
    pcb_r   = t1bf_pkg::R_BLOCK_FLAG | {3'd0, sequence_bit, 4'd0};
    lrc     = ((send_count == 8'd0) ? (pcb_i ^ apdu_length) : send_lrc) ^ data_byte;
    received_pcb_next = (receive_count == t1bf_pkg::POS_PCB) ? data_byte : received_pcb;
    received_len_next = (receive_count == t1bf_pkg::POS_LEN) ? data_byte : received_len;
    chained = received_pcb_next[t1bf_pkg::CHAIN_BIT];
    limit   = chained ? received_len_next
            : ((received_len_next >= 8'd2) ? received_len_next - 8'd2 : 8'd0);
    d       = receive_count - t1bf_pkg::DATA_START;
    forward = !last_byte && (receive_count >= t1bf_pkg::DATA_START) && (d < {1'b0, limit});

    if (kind == t1bf_pkg::IN_CMD) begin
      received_pcb_next = received_pcb;
      received_len_next = received_len;
      send_lrc_next = lrc;
      if (send_count == 8'd0) begin
        gathered_length_next = 8'd0;
        sequence_bit_next    = ~sequence_bit;
        step.res[0].data = 8'd0;
        step.res[1].data = pcb_i;
        step.res[2].data = apdu_length;
        step.res[3].data = data_byte;
        step.res[4].data = lrc;
        step.count = last_byte ? 3'd5 : 3'd4;
      end else begin
        step.res[0].data = data_byte;
        step.res[1].data = lrc;
        step.count = last_byte ? 3'd2 : 3'd1;
      end
      if (last_byte) begin
        send_count_next = 8'd0;
      end else if (send_count != 8'hff) begin
        send_count_next = send_count + 8'd1;
      end
    end else begin
      if (forward) begin
        if (gathered_length != 8'hff) begin
          gathered_length_next = gathered_length + 8'd1;
        end
        step.res[0].kind = t1bf_pkg::KIND_HOST;
        step.res[0].data = data_byte;
        step.count = 3'd1;
      end
      if (last_byte) begin
        receive_count_next = 9'd0;
        step.res[0].kind = t1bf_pkg::KIND_REPORT;
        step.count = 3'd1;
        if (({1'b0, receive_count} + 10'd1) < t1bf_pkg::MIN_ANSWER) begin
          step.res[0].status = t1bf_pkg::STATUS_ERR;
        end else if (chained) begin
          step.res[0].status = t1bf_pkg::STATUS_CHAIN;
          step.res[2].data = pcb_r;
          step.res[4].data = pcb_r;
          step.count = 3'd5;
          sequence_bit_next = ~sequence_bit;
        end else begin
          step.res[0].status_word = {status_high, status_low};
        end
      end else begin
        status_high_next = status_low;
        status_low_next  = data_byte;
        if (receive_count != 9'h1ff) begin
          receive_count_next = receive_count + 9'd1;
        end
      end
    end
    step.response_length = gathered_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_bit    <= 1'b0;
      send_count      <= 8'd0;
      send_lrc        <= 8'd0;
      receive_count   <= 9'd0;
      received_pcb    <= 8'd0;
      received_len    <= 8'd0;
      status_high     <= 8'd0;
      status_low      <= 8'd0;
      gathered_length <= 8'd0;
    end else if (accept) begin
      sequence_bit    <= sequence_bit_next;
      send_count      <= send_count_next;
      send_lrc        <= send_lrc_next;
      receive_count   <= receive_count_next;
      received_pcb    <= received_pcb_next;
      received_len    <= received_len_next;
      status_high     <= status_high_next;
      status_low      <= status_low_next;
      gathered_length <= gathered_length_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/t1_block_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// T=1 block framer
// Wraps host APDU words into I-blocks and parses card blocks.
//
// Input channel (in_valid/in_ready): kind 0 is an APDU word from the host,
// kind 1 a word received from the card; last_byte closes the APDU or block.
// Output channel (out_valid/out_ready): words to the card, payload words to
// the host and completion reports; last marks the final result of an input.
// Each input word yields zero to five result words. They are built into a
// five-entry result line and shifted out one per cycle while the receiver is
// ready, the first visible the cycle after the input is taken.
// A new input is taken when no result is pending or in the cycle the final
// pending result leaves.
// A stalled receiver holds the current result and, while results are
// pending, the input channel. Reset clears all framing state and empties
// the result line.
// ----------------------------------------------------------------------------
module t1_block_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  apdu_length,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic [15:0]      status_word,
  output logic [7:0]       response_length,
  output logic             last
);

  t1bf_pkg::step_t step;
  t1bf_pkg::result_t [t1bf_pkg::MAX_RESULTS-1:0] line;
  logic [2:0] count;
  logic [7:0] resp_len;
  logic       accept, take;

  assign out_valid = (count != 3'd0);
  assign take      = out_valid && out_ready;
  assign in_ready  = (count == 3'd0) || ((count == 3'd1) && out_ready);
  assign accept    = in_valid && in_ready;

  t1bf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .data_byte   (data_byte),
    .apdu_length (apdu_length),
    .last_byte   (last_byte),
    .step        (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (accept) begin
      count <= step.count;
    end else if (take) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line     <= step.res;
      resp_len <= step.response_length;
    end else if (take) begin
      line <= {t1bf_pkg::result_t'('0), line[t1bf_pkg::MAX_RESULTS-1:1]};
    end
  end

  assign out_kind        = line[0].kind;
  assign out_byte        = line[0].data;
  assign status          = line[0].status;
  assign status_word     = line[0].status_word;
  assign response_length = resp_len;
  assign last            = (count == 3'd1);

endmodule
`default_nettype wire

[hw/rtl/t1bf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// T=1 block framer port checker
// Watches the framer ports for handshake and result word consistency.
// ----------------------------------------------------------------------------
module t1bf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [1:0]  status,
  input wire logic [15:0] status_word,
  input wire logic        last
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result word changed");

  // take input only once pending results drain
  a_in_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || (last && out_ready))
    else $error("input taken with results pending");

  a_report_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == t1bf_pkg::KIND_REPORT |-> out_byte == 8'd0)
    else $error("report word carries a byte");

  a_status_only_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != t1bf_pkg::KIND_REPORT |-> status == 2'd0 && status_word == 16'd0)
    else $error("status on a non-report word");

  a_report_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == t1bf_pkg::KIND_REPORT && status != t1bf_pkg::STATUS_CHAIN
      |-> last)
    else $error("final report not marked last");

endmodule

bind t1_block_framer t1bf_checker u_t1bf_checker (.*);
`default_nettype wire
